FILE: hw/rtl/bsetp_pkg.sv
package bsetp_pkg;

  // Fixed-point format and image geometry
  localparam int unsigned FracBits  = 26;
  localparam int unsigned ImageSize = 512;  // power of two
  localparam int unsigned ImgLog2   = $clog2(ImageSize);

  // Field widths
  localparam int unsigned CoordW    = 9;
  localparam int unsigned ValW      = 32;
  localparam int unsigned IterW     = 16;
  localparam int unsigned StepW     = 24;
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 56;
  localparam int unsigned CfgAddrW  = 3;

  // Datapath widths
  localparam int unsigned MulW  = 33;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned MapW  = 43;  // index * span, signed

  localparam logic signed [MapW-1:0] ImgMask = MapW'(ImageSize - 1);
  localparam logic [64:0] EscLimit = 65'(4) << (2 * FracBits);

  // Register indexes
  typedef logic [CfgAddrW-1:0] cfg_idx_t;
  localparam cfg_idx_t RegMinReal  = 3'd0;
  localparam cfg_idx_t RegMinImag  = 3'd1;
  localparam cfg_idx_t RegMaxReal  = 3'd2;
  localparam cfg_idx_t RegMaxImag  = 3'd3;
  localparam cfg_idx_t RegMaxIter  = 3'd4;
  localparam cfg_idx_t RegColorStp = 3'd5;

  // Reset window is [-2.0, 2.0] on both axes
  localparam logic signed [ValW-1:0] RstMaxVal = ValW'(2) <<< FracBits;
  localparam logic signed [ValW-1:0] RstMinVal = -RstMaxVal;
  localparam logic [IterW-1:0]       RstMaxIter = 16'd250;
  localparam logic [StepW-1:0]       RstColorStp = 24'd1;

  // Microcode
  typedef enum logic [3:0] {
    S_IDLE, S_MAPR, S_MAPI, S_SETCI, S_SQR, S_SQI, S_CROSS, S_UPD, S_COLOR, S_EMIT
  } step_e;

  typedef enum logic [2:0] {A_SPANR, A_SPANI, A_MAGR, A_MAGI, A_COUNT} a_sel_e;
  typedef enum logic [2:0] {B_COL, B_ROW, B_MAGR, B_MAGI, B_STEP} b_sel_e;
  typedef enum logic [1:0] {D_NONE, D_PROD, D_SR, D_SI} dst_e;
  typedef enum logic [2:0] {
    ACT_NONE, ACT_LOAD, ACT_SETCR, ACT_SETCI, ACT_DIFF, ACT_UPDATE, ACT_EMIT
  } act_e;
  typedef enum logic [2:0] {C_NEXT, C_JUMP, C_IN, C_LIMIT, C_ESC, C_OUTFREE} cond_e;

  typedef struct packed {
    a_sel_e a_sel;
    b_sel_e b_sel;
    dst_e   dst;
    act_e   act;
    cond_e  cond;
    step_e  target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_e step);
    ucode_t w;
    w = '{a_sel: A_SPANR, b_sel: B_COL, dst: D_NONE, act: ACT_NONE,
          cond: C_NEXT, target: S_IDLE};
    unique case (step)
      S_IDLE: begin
        w.act = ACT_LOAD; w.cond = C_IN; w.target = S_MAPR;
      end
      S_MAPR: begin
        w.a_sel = A_SPANR; w.b_sel = B_COL; w.dst = D_PROD;
      end
      S_MAPI: begin
        w.a_sel = A_SPANI; w.b_sel = B_ROW; w.dst = D_PROD; w.act = ACT_SETCR;
      end
      S_SETCI: begin
        w.act = ACT_SETCI;
      end
      S_SQR: begin
        w.a_sel = A_MAGR; w.b_sel = B_MAGR; w.dst = D_SR;
        w.cond = C_LIMIT; w.target = S_COLOR;
      end
      S_SQI: begin
        w.a_sel = A_MAGI; w.b_sel = B_MAGI; w.dst = D_SI;
      end
      S_CROSS: begin
        w.a_sel = A_MAGR; w.b_sel = B_MAGI; w.dst = D_PROD; w.act = ACT_DIFF;
        w.cond = C_ESC; w.target = S_COLOR;
      end
      S_UPD: begin
        w.act = ACT_UPDATE; w.cond = C_JUMP; w.target = S_SQR;
      end
      S_COLOR: begin
        w.a_sel = A_COUNT; w.b_sel = B_STEP; w.dst = D_PROD;
      end
      S_EMIT: begin
        w.act = ACT_EMIT; w.cond = C_OUTFREE; w.target = S_IDLE;
      end
      default: begin
        w.cond = C_JUMP; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [ValW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[ValW-1:0];
    end else if (v < lo) begin
      return lo[ValW-1:0];
    end
    return v[ValW-1:0];
  endfunction

endpackage

FILE: hw/rtl/burning_ship_escape_time_pixel_top.sv
// Burning Ship escape-time evaluator, one pixel per input word.
// Input stream (s_axis): one word names a pixel by column and row. The
// pixel is mapped into the window set by the config registers, then
// z' = (|zr| + i|zi|)^2 + c is iterated from z = 0 until |z|^2 >= 4 or
// the iteration limit. Output stream (m_axis): one word per pixel with
// color, escape count and inside flag.
// Config: write cfg_wdata_i to register cfg_addr_i when cfg_we_i is high;
// only while no pixel is in flight.
// Timing: a microcoded sequencer drives a single 33x33 multiplier. Setup
// maps column and row into c; each iteration is three products plus update.
// The limit is checked before each iteration, escape once both squares exist; then the
// color is formed and the result emitted; the idle step precedes the next accept.
// One pixel is in work at a time; s_axis_tready is high only while the
// sequencer waits at its idle step.
// The result sits in an output register, so the next pixel is accepted
// while it waits; if that register is still full when the next pixel is
// done, the sequencer holds until m_axis_tready drains it.
// Reset restores the default window [-2,2]x[-2,2], limit 250, step 1,
// and empties the output register.
module burning_ship_escape_time_pixel_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bsetp_pkg::InTdataW-1:0]  s_axis_tdata,  // column, row
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bsetp_pkg::OutTdataW-1:0] m_axis_tdata,  // pixel_color, escape_count,
                                                         // inside_res
  input  logic                            cfg_we_i,
  input  logic [bsetp_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [bsetp_pkg::ValW-1:0]      cfg_wdata_i
);
  import bsetp_pkg::*;

  // Config registers
  logic signed [ValW-1:0] min_real_q, min_imag_q, max_real_q, max_imag_q;
  logic [IterW-1:0]       max_iter_q;
  logic [StepW-1:0]       color_step_q;

  // Sequencer
  step_e  pc_q, pc_d;
  ucode_t cw;

  // Datapath
  logic signed [MulW-1:0]  span_r_q, span_i_q;
  logic [CoordW-1:0]       col_q, row_q;
  logic signed [ValW-1:0]  cr_q, ci_q, zr_q, zi_q;
  logic [IterW-1:0]        count_q;
  logic signed [ProdW-1:0] prod_q;
  logic [63:0]             sr_q, si_q;
  logic signed [64:0]      diff_q;

  logic                    m_valid_q;
  logic [OutTdataW-1:0]    m_data_q;

  logic                    in_acc, out_free, esc, in_set;
  logic [ValW-1:0]         mag_r, mag_i;
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [MapW-1:0]  map_t, map_q;
  logic signed [ValW-1:0]  map_lo, map_c;
  logic signed [64:0]      nr_sh;
  logic [63:0]             cross_sh;
  logic signed [ValW-1:0]  zr_new, zi_new;

  assign cw = ucode_rom(pc_q);

  assign s_axis_tready = (cw.act == ACT_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Operand select and shared multiplier
  assign mag_r = zr_q[ValW-1] ? ValW'(-zr_q) : ValW'(zr_q);
  assign mag_i = zi_q[ValW-1] ? ValW'(-zi_q) : ValW'(zi_q);

  always_comb begin
    unique case (cw.a_sel)
      A_SPANR: mul_a = span_r_q;
      A_SPANI: mul_a = span_i_q;
      A_MAGR:  mul_a = $signed({1'b0, mag_r});
      A_MAGI:  mul_a = $signed({1'b0, mag_i});
      A_COUNT: mul_a = $signed({{(MulW-IterW){1'b0}}, count_q});
      default: mul_a = '0;
    endcase
    unique case (cw.b_sel)
      B_COL:   mul_b = $signed({{(MulW-CoordW){1'b0}}, col_q});
      B_ROW:   mul_b = $signed({{(MulW-CoordW){1'b0}}, row_q});
      B_MAGR:  mul_b = $signed({1'b0, mag_r});
      B_MAGI:  mul_b = $signed({1'b0, mag_i});
      B_STEP:  mul_b = $signed({{(MulW-StepW){1'b0}}, color_step_q});
      default: mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Coordinate mapping: truncate toward zero, then add the window edge
  assign map_t  = prod_q[MapW-1:0];
  assign map_q  = $signed(map_t + (map_t[MapW-1] ? ImgMask : '0)) >>> ImgLog2;
  assign map_lo = (cw.act == ACT_SETCR) ? min_real_q : min_imag_q;
  assign map_c  = sat32(64'(map_q) + 64'(map_lo));

  // Iteration update
  assign esc      = ({1'b0, sr_q} + {1'b0, si_q}) >= EscLimit;
  assign nr_sh    = diff_q >>> FracBits;
  assign cross_sh = prod_q[63:0] >> (FracBits - 1);
  assign zr_new   = sat32($signed(nr_sh[63:0]) + 64'(cr_q));
  assign zi_new   = sat32($signed(cross_sh) + 64'(ci_q));

  assign in_set = (count_q == max_iter_q);

  always_comb begin
    unique case (cw.cond)
      C_NEXT:    pc_d = step_e'(pc_q + 4'd1);
      C_JUMP:    pc_d = cw.target;
      C_IN:      pc_d = in_acc ? cw.target : pc_q;
      C_LIMIT:   pc_d = (count_q >= max_iter_q) ? cw.target : step_e'(pc_q + 4'd1);
      C_ESC:     pc_d = esc ? cw.target : step_e'(pc_q + 4'd1);
      C_OUTFREE: pc_d = out_free ? cw.target : pc_q;
      default:   pc_d = S_IDLE;
    endcase
  end

  // Control and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= S_IDLE;
      m_valid_q    <= 1'b0;
      min_real_q   <= RstMinVal;
      min_imag_q   <= RstMinVal;
      max_real_q   <= RstMaxVal;
      max_imag_q   <= RstMaxVal;
      max_iter_q   <= RstMaxIter;
      color_step_q <= RstColorStp;
    end else begin
      pc_q <= pc_d;
      if (cw.act == ACT_EMIT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegMinReal:  min_real_q   <= cfg_wdata_i;
          RegMinImag:  min_imag_q   <= cfg_wdata_i;
          RegMaxReal:  max_real_q   <= cfg_wdata_i;
          RegMaxImag:  max_imag_q   <= cfg_wdata_i;
          RegMaxIter:  max_iter_q   <= cfg_wdata_i[IterW-1:0];
          RegColorStp: color_step_q <= cfg_wdata_i[StepW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    span_r_q <= {max_real_q[ValW-1], max_real_q} - {min_real_q[ValW-1], min_real_q};
    span_i_q <= {max_imag_q[ValW-1], max_imag_q} - {min_imag_q[ValW-1], min_imag_q};

    unique case (cw.dst)
      D_PROD:  prod_q <= mul_p;
      D_SR:    sr_q   <= mul_p[63:0];
      D_SI:    si_q   <= mul_p[63:0];
      default: ;
    endcase

    unique case (cw.act)
      ACT_LOAD: begin
        if (in_acc) begin
          col_q   <= s_axis_tdata[CoordW-1:0];
          row_q   <= s_axis_tdata[2*CoordW-1:CoordW];
          zr_q    <= '0;
          zi_q    <= '0;
          count_q <= '0;
        end
      end
      ACT_SETCR: cr_q <= map_c;
      ACT_SETCI: ci_q <= map_c;
      ACT_DIFF:  diff_q <= $signed({1'b0, sr_q}) - $signed({1'b0, si_q});
      ACT_UPDATE: begin
        zr_q    <= zr_new;
        zi_q    <= zi_new;
        count_q <= count_q + 1'b1;
      end
      ACT_EMIT: begin
        if (out_free) begin
          m_data_q <= {{(OutTdataW-ValW-IterW-1){1'b0}}, in_set, count_q,
                       in_set ? {ValW{1'b0}} : prod_q[ValW-1:0]};
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/bsetp_chk.sv
module bsetp_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bsetp_pkg::OutTdataW-1:0] m_axis_tdata
);

  // one pixel in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a pixel is in work");

  // a new result only comes out of a busy sequencer
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result word without pixel in work");

  // inside pixels carry no color
  a_inside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[48] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("inside pixel with nonzero color");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

endmodule

bind burning_ship_escape_time_pixel_top bsetp_chk u_bsetp_chk (.*);

FILE: tb/burning_ship_escape_time_pixel_top_test.sv
module burning_ship_escape_time_pixel_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bsetp_pkg::*;

  typedef longint unsigned u64_t;

  // |z|^2 bound, 2*FracBits fraction bits
  localparam u64_t EscBound = u64_t'(4) << (2 * FracBits);

  typedef struct {
    logic [ValW-1:0]  color;
    logic [IterW-1:0] count;
    logic             in_set;
  } pixel_res_t;

  function automatic logic signed [ValW-1:0] clamp_q26(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < longint'(32'sh8000_0000)) return 32'sh8000_0000;
    return v[ValW-1:0];
  endfunction

  function automatic u64_t magnitude(input logic signed [ValW-1:0] v);
    return (v < 0) ? u64_t'(-longint'(v)) : u64_t'(longint'(v));
  endfunction

  class pixel_board;
    logic signed [ValW-1:0] re_lo, im_lo, re_hi, im_hi;
    logic [IterW-1:0]       iter_limit;
    logic [StepW-1:0]       color_step;
    pixel_res_t             due_q[$];
    int                     errors;

    function new();
      re_lo      = RstMinVal;
      im_lo      = RstMinVal;
      re_hi      = RstMaxVal;
      im_hi      = RstMaxVal;
      iter_limit = RstMaxIter;
      color_step = RstColorStp;
      errors     = 0;
    endfunction

    function void set_reg(input cfg_idx_t idx, input logic [ValW-1:0] val);
      case (idx)
        RegMinReal:  re_lo = val;
        RegMinImag:  im_lo = val;
        RegMaxReal:  re_hi = val;
        RegMaxImag:  im_hi = val;
        RegMaxIter:  iter_limit = val[IterW-1:0];
        RegColorStp: color_step = val[StepW-1:0];
        default: ;
      endcase
    endfunction

    // lo + idx*(hi-lo)/ImageSize, quotient truncated toward zero
    function logic signed [ValW-1:0] axis_point(input logic signed [ValW-1:0] lo,
                                                input logic signed [ValW-1:0] hi,
                                                input logic [CoordW-1:0] idx);
      longint span;
      longint q;
      span = longint'(hi) - longint'(lo);
      q = longint'(idx) * span / longint'(ImageSize);
      return clamp_q26(longint'(lo) + q);
    endfunction

    function void note_pixel(input logic [CoordW-1:0] col, input logic [CoordW-1:0] row);
      logic signed [ValW-1:0] cr, ci, zr, zi;
      u64_t        ar, ai, sr, si;
      longint      nr, ni;
      int unsigned n;
      pixel_res_t  res;
      cr = axis_point(re_lo, re_hi, col);
      ci = axis_point(im_lo, im_hi, row);
      zr = '0;
      zi = '0;
      n  = 0;
      while (n < iter_limit) begin
        ar = magnitude(zr);
        ai = magnitude(zi);
        sr = ar * ar;
        si = ai * ai;
        if (sr + si >= EscBound) break;
        // >>> on a signed value rounds toward minus infinity
        nr = ((longint'(sr) - longint'(si)) >>> FracBits) + longint'(cr);
        ni = longint'(((ar * ai) << 1) >> FracBits) + longint'(ci);
        zr = clamp_q26(nr);
        zi = clamp_q26(ni);
        n++;
      end
      res.count  = n[IterW-1:0];
      res.in_set = (n == iter_limit);
      res.color  = res.in_set ? '0 : ValW'(n * color_step);
      due_q.push_back(res);
    endfunction

    function void check_pixel(input logic [OutTdataW-1:0] word);
      pixel_res_t exp_res;
      if (due_q.size() == 0) begin
        $error("result word %h with no pixel pending", word);
        errors++;
        return;
      end
      exp_res = due_q.pop_front();
      if (word[ValW-1:0] !== exp_res.color) begin
        $error("pixel_color: expected %0h, got %0h", exp_res.color, word[ValW-1:0]);
        errors++;
      end
      if (word[ValW+IterW-1:ValW] !== exp_res.count) begin
        $error("escape_count: expected %0d, got %0d", exp_res.count,
               word[ValW+IterW-1:ValW]);
        errors++;
      end
      if (word[ValW+IterW] !== exp_res.in_set) begin
        $error("inside_res: expected %0b, got %0b", exp_res.in_set, word[ValW+IterW]);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr_i = '0;
  logic [ValW-1:0]      cfg_wdata_i = '0;

  bit         calm = 1'b0;      // no idling on either side
  bit         hold_req = 1'b0;  // ask the sink for one long hold-off
  pixel_board board = new();

  burning_ship_escape_time_pixel_top uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_pixel(input logic [CoordW-1:0] col, input logic [CoordW-1:0] row);
    if (!calm && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InTdataW'({row, col});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_pixel(col, row);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [ValW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.set_reg(idx, val);
  endtask

  task automatic apply_setting(input logic signed [ValW-1:0] re_lo, im_lo, re_hi, im_hi,
                               input logic [IterW-1:0] limit,
                               input logic [StepW-1:0] step);
    write_reg(RegMinReal, re_lo);
    write_reg(RegMinImag, im_lo);
    write_reg(RegMaxReal, re_hi);
    write_reg(RegMaxImag, im_hi);
    write_reg(RegMaxIter, ValW'(limit));
    write_reg(RegColorStp, ValW'(step));
    cfg_we_i <= 1'b0;
  endtask

  // wild: arbitrary 32-bit window edges, mostly instant escapes
  task automatic random_phase(input int count, input bit wild);
    logic signed [ValW-1:0] cx, cy, hx, hy, swap;
    logic signed [ValW-1:0] rl, il, rh, ih;
    if (wild) begin
      rl = $urandom;
      il = $urandom;
      rh = $urandom;
      ih = $urandom;
    end else begin
      cx = int'($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
      cy = int'($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
      hx = $urandom_range(32'h0800_0000, 32'h0001_0000);
      hy = $urandom_range(32'h0800_0000, 32'h0001_0000);
      rl = cx - hx;
      rh = cx + hx;
      il = cy - hy;
      ih = cy + hy;
      if ($urandom_range(3) == 0) begin
        swap = rl;
        rl = rh;
        rh = swap;
      end
      if ($urandom_range(3) == 0) begin
        swap = il;
        il = ih;
        ih = swap;
      end
    end
    apply_setting(rl, il, rh, ih, IterW'($urandom_range(48, 1)),
                  StepW'($urandom_range(24'hFF_FFFF)));
    repeat (count) begin
      send_pixel(CoordW'($urandom_range(ImageSize - 1)), CoordW'($urandom_range(ImageSize - 1)));
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window: corners, center (c = 0), alternating bit patterns
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd0, 9'd511);
    send_pixel(9'd511, 9'd0);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd255, 9'd257);
    send_pixel(9'd1, 9'd510);
    send_pixel(9'h155, 9'h0AA);
    send_pixel(9'h0AA, 9'h155);
    drain();

    // full signed range, imaginary axis reversed
    apply_setting(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  16'd8, 24'hFF_FFFF);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd0, 9'd511);
    drain();

    // zero limit: no iteration, always inside
    apply_setting(RstMinVal, RstMinVal, RstMaxVal, RstMaxVal, 16'd0, 24'h00_0123);
    send_pixel(9'd3, 9'd4);
    send_pixel(9'd256, 9'd256);
    drain();

    // top limit: c = 0 never escapes
    apply_setting(RstMinVal, RstMinVal, RstMaxVal, RstMaxVal, 16'hFFFF, 24'd1);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd300, 9'd100);
    drain();

    // limit one, zero color step, narrow window near the antenna
    apply_setting(-32'sh0733_3333, -32'sh0100_0000, -32'sh06CC_CCCD, 32'sh0100_0000,
                  16'd1, 24'd0);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd128, 9'd384);
    drain();

    hold_req = 1'b1;
    for (int p = 0; p < 10; p++) begin
      if (p == 9) calm = 1'b1;
      random_phase(105, p == 3 || p == 7);
    end

    repeat (50) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_pixel(m_axis_tdata);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 3000;
      end else if (stall_left == 0 && !calm && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(14, 1);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
